// File: hw/rtl/sbdt_pkg.sv
// Shared types, codes and reset values for the shared-buffer admission block.
`timescale 1ns / 1ps

package sbdt_pkg;

  // Default sizing of the queue set.
  localparam int unsigned NUM_QUEUES_DEF  = 8;
  localparam int unsigned QUEUE_DEPTH_DEF = 1024;

  // Stream widths.
  localparam int unsigned S_DATA_W = 24;
  localparam int unsigned M_DATA_W = 48;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_SHARED_BUF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_EXP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ECN_EN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ECN_THR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PKTS   = 3'd4;

  localparam logic [23:0]        SHARED_BUF_RST = 24'd204800;
  localparam logic signed [5:0]  ALPHA_EXP_RST  = 6'sd0;
  localparam logic               ECN_EN_RST     = 1'b0;
  localparam logic [23:0]        ECN_THR_RST    = 24'd102400;
  localparam logic [10:0]        MAX_PKTS_RST   = 11'd1024;

  // Request kinds.
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // Drop reasons.
  localparam logic [1:0] DROP_NONE   = 2'd0;
  localparam logic [1:0] DROP_THRESH = 2'd1;
  localparam logic [1:0] DROP_FULL   = 2'd2;

  // A classified request as it travels from the front to the back.
  typedef struct packed {
    logic        req_type;
    logic        in_range;
    logic [2:0]  queue_index;
    logic [15:0] packet_size;
  } req_t;

  // One result, packed so that accepted lands in the lowest bit.
  typedef struct packed {
    logic [23:0] queue_bytes_after;
    logic        ce_mark;
    logic [15:0] dequeued_size;
    logic        dequeue_valid;
    logic [1:0]  drop_reason;
    logic        accepted;
  } rsp_t;

endpackage

// File: hw/rtl/sbdt_front.sv
// Input stage: accepts request beats, decodes and range-checks them.
`timescale 1ns / 1ps

module sbdt_front #(
  parameter int unsigned NUM_QUEUES = sbdt_pkg::NUM_QUEUES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic [sbdt_pkg::S_DATA_W-1:0] s_data_i,
  input  logic                          s_user_i,
  output logic                          req_valid_o,
  input  logic                          req_ready_i,
  output sbdt_pkg::req_t                req_o
);

  logic           valid_q, valid_d;
  sbdt_pkg::req_t req_q, req_d;
  logic           take;

  assign s_ready_o = !valid_q || req_ready_i;
  assign take      = s_valid_i && s_ready_o;

  always_comb begin
    req_d             = req_q;
    req_d.req_type    = s_user_i;
    req_d.queue_index = s_data_i[2:0];
    req_d.packet_size = s_data_i[18:3];
    req_d.in_range    = (32'(s_data_i[2:0]) < NUM_QUEUES);
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (req_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q <= req_d;
    end
  end

  assign req_valid_o = valid_q;
  assign req_o       = req_q;

endmodule

// File: hw/rtl/sbdt_fifo.sv
// Two-entry request queue between the front and the back.
`timescale 1ns / 1ps

module sbdt_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  sbdt_pkg::req_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output sbdt_pkg::req_t pop_data_o
);

  logic [1:0]     cnt_q, cnt_d;
  logic           wp_q, rp_q;
  sbdt_pkg::req_t entry_q [2];
  logic           push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wp_q <= !wp_q;
      end
      if (pop) begin
        rp_q <= !rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wp_q] <= push_data_i;
    end
  end

endmodule

// File: hw/rtl/sbdt_back.sv
// Execution stage: queue counters, packet size store, admission and result register.
`timescale 1ns / 1ps

module sbdt_back #(
  parameter int unsigned NUM_QUEUES  = sbdt_pkg::NUM_QUEUES_DEF,
  parameter int unsigned QUEUE_DEPTH = sbdt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sbdt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sbdt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            req_valid_i,
  output logic                            req_ready_o,
  input  sbdt_pkg::req_t                  req_i,
  output logic                            m_valid_o,
  input  logic                            m_ready_i,
  output sbdt_pkg::rsp_t                  m_rsp_o
);

  localparam int unsigned QW        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned PW        = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW        = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMPW      = (CW > 11) ? CW : 11;
  localparam int unsigned AW        = QW + PW;
  localparam int unsigned MEM_DEPTH = NUM_QUEUES << PW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;

  // Configuration registers.
  logic [23:0]       sb_q;
  logic signed [5:0] alpha_q;
  logic              ecn_en_q;
  logic [23:0]       ecn_thr_q;
  logic [10:0]       maxp_q;

  // Shared and per-queue state.
  logic [23:0]   used_q;
  logic [23:0]   qbytes_q [NUM_QUEUES];
  logic [CW-1:0] qcnt_q   [NUM_QUEUES];
  logic [PW-1:0] head_q   [NUM_QUEUES];
  logic [PW-1:0] tail_q   [NUM_QUEUES];
  logic [15:0]   mem_q    [MEM_DEPTH];
  logic [15:0]   rd_data_q;

  // Sequencer and per-request registers.
  logic [1:0]     state_q, state_d;
  sbdt_pkg::req_t cur_q;
  logic [55:0]    thr_q;
  logic           shared_over_q, full_q, empty_q;
  logic           out_valid_q, out_valid_d;
  sbdt_pkg::rsp_t out_q, out_d;

  logic [QW-1:0]   cq;
  logic [23:0]     qb_cur;
  logic [CW-1:0]   cnt_cur;
  logic [PW-1:0]   head_cur, tail_cur;
  logic [23:0]     avail;
  logic [5:0]      neg_alpha;
  logic [55:0]     thr_calc;
  logic            shared_over_calc, full_calc;
  logic [24:0]     lhs;
  logic            fire, enq_ok, deq_ok;
  logic [23:0]     qb_next, used_next;
  logic [PW-1:0]   head_next, tail_next;

  assign cq       = QW'(cur_q.queue_index);
  assign qb_cur   = qbytes_q[cq];
  assign cnt_cur  = qcnt_q[cq];
  assign head_cur = head_q[cq];
  assign tail_cur = tail_q[cq];

  assign req_ready_o = (state_q == ST_IDLE);
  assign fire        = (state_q == ST_EXEC) && (!out_valid_q || m_ready_i);

  // Free buffer scaled by the signed alpha exponent, and the shared-buffer and full checks.
  always_comb begin
    avail     = (sb_q > used_q) ? (sb_q - used_q) : 24'd0;
    neg_alpha = 6'(-alpha_q);
    if (alpha_q[5]) begin
      thr_calc = {32'd0, avail} >> neg_alpha;
    end else begin
      thr_calc = {32'd0, avail} << alpha_q[4:0];
    end
    shared_over_calc = ({1'b0, used_q} + 25'(cur_q.packet_size)) > {1'b0, sb_q};
    full_calc = (CMPW'(cnt_cur) >= CMPW'(maxp_q)) || (cnt_cur >= CW'(QUEUE_DEPTH));
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    enq_ok      = 1'b0;
    deq_ok      = 1'b0;
    lhs         = {1'b0, qb_cur} + 25'(cur_q.packet_size);
    qb_next     = qb_cur;
    used_next   = used_q;
    head_next   = (head_cur == PW'(QUEUE_DEPTH - 1)) ? '0 : head_cur + PW'(1);
    tail_next   = (tail_cur == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_cur + PW'(1);

    if (out_valid_q && m_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (fire) begin
          out_d = '0;
          if (cur_q.in_range) begin
            if (cur_q.req_type == sbdt_pkg::REQ_ENQ) begin
              if (({31'd0, lhs} > thr_q) || shared_over_q) begin
                out_d.drop_reason = sbdt_pkg::DROP_THRESH;
              end else if (full_q) begin
                out_d.drop_reason = sbdt_pkg::DROP_FULL;
              end else begin
                enq_ok         = 1'b1;
                out_d.accepted = 1'b1;
                qb_next        = lhs[23:0];
                used_next      = used_q + 24'(cur_q.packet_size);
              end
            end else if (!empty_q) begin
              deq_ok              = 1'b1;
              qb_next             = (qb_cur >= 24'(rd_data_q)) ? qb_cur - 24'(rd_data_q) : 24'd0;
              used_next           = (used_q >= 24'(rd_data_q)) ? used_q - 24'(rd_data_q) : 24'd0;
              out_d.dequeue_valid = 1'b1;
              out_d.dequeued_size = rd_data_q;
              out_d.ce_mark       = ecn_en_q && (qb_next > ecn_thr_q);
            end
            out_d.queue_bytes_after = qb_next;
          end else if (cur_q.req_type == sbdt_pkg::REQ_ENQ) begin
            out_d.drop_reason = sbdt_pkg::DROP_FULL;
          end
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_q        <= sbdt_pkg::SHARED_BUF_RST;
      alpha_q     <= sbdt_pkg::ALPHA_EXP_RST;
      ecn_en_q    <= sbdt_pkg::ECN_EN_RST;
      ecn_thr_q   <= sbdt_pkg::ECN_THR_RST;
      maxp_q      <= sbdt_pkg::MAX_PKTS_RST;
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      used_q      <= 24'd0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        qbytes_q[i] <= '0;
        qcnt_q[i]   <= '0;
        head_q[i]   <= '0;
        tail_q[i]   <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          sbdt_pkg::CFG_SHARED_BUF: sb_q      <= cfg_data_i;
          sbdt_pkg::CFG_ALPHA_EXP:  alpha_q   <= cfg_data_i[5:0];
          sbdt_pkg::CFG_ECN_EN:     ecn_en_q  <= cfg_data_i[0];
          sbdt_pkg::CFG_ECN_THR:    ecn_thr_q <= cfg_data_i;
          sbdt_pkg::CFG_MAX_PKTS:   maxp_q    <= cfg_data_i[10:0];
          default: begin
          end
        endcase
      end
      if (enq_ok || deq_ok) begin
        used_q       <= used_next;
        qbytes_q[cq] <= qb_next;
      end
      if (enq_ok) begin
        qcnt_q[cq] <= cnt_cur + CW'(1);
        tail_q[cq] <= tail_next;
      end
      if (deq_ok) begin
        qcnt_q[cq] <= cnt_cur - CW'(1);
        head_q[cq] <= head_next;
      end
    end
  end

  // Per-request registers; nothing in the queue state changes between READ and EXEC.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && req_valid_i) begin
      cur_q <= req_i;
    end
    if (state_q == ST_READ) begin
      thr_q         <= thr_calc;
      shared_over_q <= shared_over_calc;
      full_q        <= full_calc;
      empty_q       <= (cnt_cur == '0);
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

  // Packet size store: head read while the request sits in READ, tail write on admission.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      rd_data_q <= mem_q[AW'({cq, head_cur})];
    end
    if (enq_ok) begin
      mem_q[AW'({cq, tail_cur})] <= cur_q.packet_size;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_rsp_o   = out_q;

endmodule

// File: hw/rtl/shared_buffer_dt_admission.sv
// Top level of the shared-buffer admission block with dynamic thresholds and ECN marking.
//
// Requests enter on the s_axis channel, one beat each: tuser says enqueue or dequeue,
// tdata carries the queue index and the packet size. Each request yields exactly one
// result beat on m_axis, in request order: admission outcome and drop reason for an
// enqueue, head packet size and ECN mark for a dequeue, and the queue's byte count.
// The user must write registers through the cfg port only while no request is in
// flight; the block itself does not enforce this.
//
// The execution sequencer handles one request at a time and takes the next only once
// the last has left EXEC: IDLE takes a request, READ reads the head entry of the packet
// size store and scales the free buffer, EXEC compares and updates the counters.
// A two-entry queue and an input register let up to three requests be taken ahead.
//
// Reset clears all counters and pointers and loads the register defaults; the size
// store is not cleared. When m_axis stalls, the result register holds its beat, the
// sequencer waits, and s_axis_tready falls once the request queue is full and the
// input register holds a beat as well.
`timescale 1ns / 1ps

module shared_buffer_dt_admission #(
  parameter int unsigned NUM_QUEUES  = sbdt_pkg::NUM_QUEUES_DEF,
  parameter int unsigned QUEUE_DEPTH = sbdt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sbdt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sbdt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // queue_index [2:0], packet_size [18:3], zero fill [23:19]
  input  logic [sbdt_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // req_type [0]
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // accepted [0], drop_reason [2:1], dequeue_valid [3], dequeued_size [19:4],
  // ce_mark [20], queue_bytes_after [44:21], zero fill [47:45]
  output logic [sbdt_pkg::M_DATA_W-1:0]   m_axis_tdata
);

  logic           fr_valid, fr_ready;
  sbdt_pkg::req_t fr_req;
  logic           bk_valid, bk_ready;
  sbdt_pkg::req_t bk_req;
  sbdt_pkg::rsp_t rsp;

  sbdt_front #(
    .NUM_QUEUES (NUM_QUEUES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_user_i    (s_axis_tuser),
    .req_valid_o (fr_valid),
    .req_ready_i (fr_ready),
    .req_o       (fr_req)
  );

  sbdt_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_req),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_req)
  );

  sbdt_back #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .req_valid_i (bk_valid),
    .req_ready_o (bk_ready),
    .req_i       (bk_req),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_rsp_o     (rsp)
  );

  assign m_axis_tdata = {3'b000, rsp};

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the shared-buffer admission block: directed rows, random phases.
`timescale 1ns / 1ps

module testbench;
  import sbdt_pkg::*;

  localparam int NQ          = NUM_QUEUES_DEF;
  localparam int DEPTH       = QUEUE_DEPTH_DEF;
  localparam int PTR_W       = $clog2(DEPTH);
  localparam int PHASES      = 6;
  localparam int PHASE_BEATS = 110;
  localparam int SETTLE      = 8;
  localparam int MAX_REPORTS = 100;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  // For a request row idx is the queue and val the packet size; for a register row
  // idx is the register index and val the data written.
  typedef struct {
    row_kind_e   kind;
    logic        req;
    logic [2:0]  idx;
    logic [23:0] val;
    bit          typed;
    rsp_t        want;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata = '0;
  logic                  s_axis_tuser = REQ_ENQ;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_axis_tdata;

  shared_buffer_dt_admission u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mirror of the register file.
  logic [23:0]       cfg_buf   = SHARED_BUF_RST;
  logic signed [5:0] cfg_alpha = ALPHA_EXP_RST;
  logic              cfg_ecn   = ECN_EN_RST;
  logic [23:0]       cfg_thr   = ECN_THR_RST;
  logic [10:0]       cfg_cap   = MAX_PKTS_RST;

  // Mirror of the buffer state; the size ring needs no reset value.
  logic [23:0]      used_bytes = '0;
  logic [23:0]      q_bytes [NQ];
  logic [10:0]      q_pkts  [NQ];
  logic [PTR_W-1:0] q_head  [NQ];
  logic [PTR_W-1:0] q_tail  [NQ];
  logic [15:0]      size_ring [NQ][DEPTH];

  rsp_t pending_outcomes [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_fail = 0;
  int n_checked = 0;
  int n_admitted = 0;
  int n_drop_thresh = 0;
  int n_drop_full = 0;
  int n_popped = 0;
  int n_marked = 0;
  int n_empty_pops = 0;

  stim_row_t directed_rows [36] = '{
    '{ROW_REQ, REQ_DEQ, 3'd0, 24'd0,     1'b1, '0},
    '{ROW_REQ, REQ_ENQ, 3'd0, 24'd65535, 1'b1, '{24'd65535, 1'b0, 16'd0, 1'b0, DROP_NONE, 1'b1}},
    '{ROW_REQ, REQ_ENQ, 3'd0, 24'd0,     1'b1, '{24'd65535, 1'b0, 16'd0, 1'b0, DROP_NONE, 1'b1}},
    '{ROW_REQ, REQ_ENQ, 3'd1, 24'd1,     1'b1, '{24'd1, 1'b0, 16'd0, 1'b0, DROP_NONE, 1'b1}},
    '{ROW_REQ, REQ_ENQ, 3'd0, 24'd65535, 1'b0, '0},
    '{ROW_REQ, REQ_ENQ, 3'd0, 24'd65535, 1'b0, '0},
    '{ROW_REQ, REQ_ENQ, 3'd2, 24'd65535, 1'b0, '0},
    '{ROW_REQ, REQ_ENQ, 3'd3, 24'd65535, 1'b0, '0},
    '{ROW_REQ, REQ_DEQ, 3'd0, 24'd0,     1'b0, '0},
    '{ROW_REQ, REQ_DEQ, 3'd0, 24'd0,     1'b0, '0},
    '{ROW_REQ, REQ_DEQ, 3'd0, 24'd0,     1'b0, '0},
    '{ROW_REQ, REQ_DEQ, 3'd1, 24'd0,     1'b0, '0},
    '{ROW_REQ, REQ_DEQ, 3'd2, 24'd0,     1'b0, '0},
    '{ROW_CFG, REQ_ENQ, CFG_ECN_EN,   24'd1, 1'b0, '0},
    '{ROW_CFG, REQ_ENQ, CFG_ECN_THR,  24'd0, 1'b0, '0},
    '{ROW_CFG, REQ_ENQ, CFG_MAX_PKTS, 24'd2, 1'b0, '0},
    '{ROW_REQ, REQ_ENQ, 3'd4, 24'd100,   1'b0, '0},
    '{ROW_REQ, REQ_ENQ, 3'd4, 24'd200,   1'b0, '0},
    '{ROW_REQ, REQ_ENQ, 3'd4, 24'd300,   1'b1, '{24'd300, 1'b0, 16'd0, 1'b0, DROP_FULL, 1'b0}},
    '{ROW_CFG, REQ_ENQ, CFG_ALPHA_EXP, {18'd0, 6'(-16)}, 1'b0, '0},
    // Full and over threshold at once: the threshold wins.
    '{ROW_REQ, REQ_ENQ, 3'd4, 24'd1,     1'b1, '{24'd300, 1'b0, 16'd0, 1'b0, DROP_THRESH, 1'b0}},
    '{ROW_REQ, REQ_DEQ, 3'd4, 24'd0,     1'b1, '{24'd200, 1'b1, 16'd100, 1'b1, DROP_NONE, 1'b0}},
    '{ROW_REQ, REQ_DEQ, 3'd4, 24'd0,     1'b0, '0},
    '{ROW_CFG, REQ_ENQ, CFG_ALPHA_EXP,  24'd16,       1'b0, '0},
    '{ROW_CFG, REQ_ENQ, CFG_MAX_PKTS,   24'd0,        1'b0, '0},
    '{ROW_CFG, REQ_ENQ, CFG_SHARED_BUF, 24'hFFFFFF,   1'b0, '0},
    '{ROW_CFG, REQ_ENQ, CFG_ECN_THR,    24'hFFFFFF,   1'b0, '0},
    '{ROW_REQ, REQ_ENQ, 3'd5, 24'd65535, 1'b1, '{24'd0, 1'b0, 16'd0, 1'b0, DROP_FULL, 1'b0}},
    '{ROW_CFG, REQ_ENQ, CFG_MAX_PKTS,   24'd2047,     1'b0, '0},
    '{ROW_REQ, REQ_ENQ, 3'd5, 24'd65535, 1'b0, '0},
    // Shrink the buffer below what is already in use.
    '{ROW_CFG, REQ_ENQ, CFG_SHARED_BUF, 24'd1,        1'b0, '0},
    '{ROW_REQ, REQ_ENQ, 3'd6, 24'd0,     1'b0, '0},
    '{ROW_REQ, REQ_DEQ, 3'd5, 24'd0,     1'b0, '0},
    '{ROW_REQ, REQ_ENQ, 3'd5, 24'd1,     1'b0, '0},
    '{ROW_REQ, REQ_ENQ, 3'd5, 24'd1,     1'b0, '0},
    '{ROW_REQ, REQ_DEQ, 3'd5, 24'd0,     1'b0, '0}
  };

  function automatic rsp_t buffer_outcome(input logic req, input logic [2:0] q,
                                          input logic [15:0] size);
    rsp_t        r;
    logic [63:0] free_bytes;
    logic [63:0] dyn_limit;
    logic [10:0] cap;
    logic [15:0] head_size;
    int          shift;
    r = '0;
    shift = int'(cfg_alpha);
    free_bytes = (cfg_buf > used_bytes) ? 64'(cfg_buf - used_bytes) : 64'd0;
    dyn_limit = (shift >= 0) ? (free_bytes << shift) : (free_bytes >> (-shift));
    cap = (cfg_cap > 11'(DEPTH)) ? 11'(DEPTH) : cfg_cap;
    if (req == REQ_ENQ) begin
      if (64'(q_bytes[q]) + 64'(size) > dyn_limit ||
          64'(used_bytes) + 64'(size) > 64'(cfg_buf)) begin
        r.drop_reason = DROP_THRESH;
        n_drop_thresh++;
      end else if (q_pkts[q] >= cap) begin
        r.drop_reason = DROP_FULL;
        n_drop_full++;
      end else begin
        size_ring[q][q_tail[q]] = size;
        q_tail[q] = q_tail[q] + PTR_W'(1);
        q_pkts[q] = q_pkts[q] + 11'd1;
        q_bytes[q] = q_bytes[q] + 24'(size);
        used_bytes = used_bytes + 24'(size);
        r.accepted = 1'b1;
        n_admitted++;
      end
    end else if (q_pkts[q] != 0) begin
      head_size = size_ring[q][q_head[q]];
      q_head[q] = q_head[q] + PTR_W'(1);
      q_pkts[q] = q_pkts[q] - 11'd1;
      q_bytes[q] = (q_bytes[q] >= 24'(head_size)) ? q_bytes[q] - 24'(head_size) : '0;
      used_bytes = (used_bytes >= 24'(head_size)) ? used_bytes - 24'(head_size) : '0;
      r.dequeue_valid = 1'b1;
      r.dequeued_size = head_size;
      r.ce_mark = cfg_ecn && (q_bytes[q] > cfg_thr);
      n_popped++;
      if (r.ce_mark) n_marked++;
    end else begin
      n_empty_pops++;
    end
    r.queue_bytes_after = q_bytes[q];
    return r;
  endfunction

  task automatic set_idling(input int regime);
    case (regime)
      0: begin
        send_idle_pct = 23;
        recv_idle_pct = 85;
      end
      1: begin
        send_idle_pct = 85;
        recv_idle_pct = 23;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // Entered and left at a falling edge. Prediction happens at the accepting edge,
  // so the mirror always sees requests in the order the block takes them.
  task automatic issue_request(input logic req, input logic [2:0] q, input logic [15:0] size,
                               input bit typed, input rsp_t want);
    rsp_t model_rsp;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = req;
    s_axis_tdata = {5'd0, size, q};
    do @(posedge clk_i); while (!s_axis_tready);
    model_rsp = buffer_outcome(req, q, size);
    pending_outcomes.push_back(typed ? want : model_rsp);
    @(negedge clk_i);
  endtask

  // Hold the request side until every outstanding beat has come back.
  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_SHARED_BUF: cfg_buf = data;
      CFG_ALPHA_EXP:  cfg_alpha = data[5:0];
      CFG_ECN_EN:     cfg_ecn = data[0];
      CFG_ECN_THR:    cfg_thr = data;
      CFG_MAX_PKTS:   cfg_cap = data[10:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [23:0] buf_bytes, input int alpha, input logic ecn,
                            input logic [23:0] thr, input logic [10:0] cap);
    wait_idle();
    write_reg(CFG_SHARED_BUF, buf_bytes);
    write_reg(CFG_ALPHA_EXP, {18'd0, 6'(alpha)});
    write_reg(CFG_ECN_EN, {23'd0, ecn});
    write_reg(CFG_ECN_THR, thr);
    write_reg(CFG_MAX_PKTS, {13'd0, cap});
  endtask

  function automatic logic [15:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return 16'd0;
    if (r < 5) return 16'hFFFF;
    if (r < 20) return 16'($urandom_range(1, 8));
    if (r < 45) return 16'($urandom_range(1, 64));
    if (r < 75) return 16'($urandom_range(1, 4000));
    return 16'($urandom_range(1, 65535));
  endfunction

  task automatic compare_field(input string name, input logic [23:0] want,
                               input logic [23:0] got);
    if (want !== got) begin
      n_fail++;
      if (n_fail <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_beat(input rsp_t got);
    rsp_t want;
    if (pending_outcomes.size() == 0) begin
      n_fail++;
      if (n_fail <= MAX_REPORTS)
        $display("%0t: result beat with no request outstanding, expected none, actual %h",
                 $time, got);
      return;
    end
    want = pending_outcomes.pop_front();
    n_checked++;
    compare_field("accepted", 24'(want.accepted), 24'(got.accepted));
    compare_field("drop_reason", 24'(want.drop_reason), 24'(got.drop_reason));
    compare_field("dequeue_valid", 24'(want.dequeue_valid), 24'(got.dequeue_valid));
    compare_field("dequeued_size", 24'(want.dequeued_size), 24'(got.dequeued_size));
    compare_field("ce_mark", 24'(want.ce_mark), 24'(got.ce_mark));
    compare_field("queue_bytes_after", want.queue_bytes_after, got.queue_bytes_after);
  endtask

  // Result side: sample at the rising edge, change ready at the falling edge.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready)
        check_beat(rsp_t'(m_axis_tdata[$bits(rsp_t)-1:0]));
      @(negedge clk_i);
      m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("Run did not finish in time, %0d beats still outstanding.",
             pending_outcomes.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    int   enq_pct;
    logic req;
    logic [2:0] q;
    logic [2:0] hot_q;

    for (int i = 0; i < NQ; i++) begin
      q_bytes[i] = '0;
      q_pkts[i] = '0;
      q_head[i] = '0;
      q_tail[i] = '0;
    end
    set_idling(0);
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(directed_rows[i].idx, directed_rows[i].val);
      end else begin
        issue_request(directed_rows[i].req, directed_rows[i].idx, directed_rows[i].val[15:0],
                      directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          set_config(24'd204800, 0, 1'b1, 24'd30000, 11'd1024);
          enq_pct = 60;
        end
        1: begin
          set_config(24'hFFFFFF, 16, 1'b1, 24'hFFFFFF, 11'd6);
          enq_pct = 65;
        end
        2: begin
          // Usually lands below the bytes left over from the phase before.
          set_config(24'd40000, -2, 1'b1, 24'd0, 11'd1024);
          enq_pct = 35;
        end
        3: begin
          set_config(24'd500000, -16, 1'b0, 24'd102400, 11'd1);
          enq_pct = 50;
        end
        4: begin
          set_config(24'd2000000, 3, 1'b1, 24'd100000, 11'd2047);
          enq_pct = 55;
        end
        default: begin
          set_config(24'($urandom_range(1, 24'hFFFFFF)), int'($urandom_range(0, 32)) - 16,
                     1'($urandom_range(0, 1)), 24'($urandom_range(0, 300000)),
                     11'($urandom_range(1, 1024)));
          enq_pct = 55;
        end
      endcase
      set_idling(phase / 2);
      hot_q = 3'(phase);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        req = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
        q = ($urandom_range(0, 99) < 40) ? hot_q : 3'($urandom_range(0, NQ - 1));
        issue_request(req, q, pick_size(), 1'b0, '0);
      end
    end

    // Empty every queue, then run one queue past a small capacity and drain it again.
    set_config(24'hFFFFFF, 0, 1'b1, 24'd40000, 11'd4);
    set_idling(2);
    for (int i = 0; i < NQ; i++)
      while (q_pkts[i] != 0) issue_request(REQ_DEQ, 3'(i), 16'd0, 1'b0, '0);
    for (int i = 0; i < 8; i++)
      issue_request(REQ_ENQ, 3'(NQ - 1), 16'($urandom_range(1, 64)), 1'b0, '0);
    while (q_pkts[NQ - 1] != 0)
      issue_request(REQ_DEQ, 3'(NQ - 1), 16'($urandom_range(0, 65535)), 1'b0, '0);
    repeat (2) issue_request(REQ_DEQ, 3'(NQ - 1), 16'd0, 1'b0, '0);

    s_axis_tvalid = 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Checked %0d result beats: %0d admitted, %0d threshold drops, %0d full drops.",
             n_checked, n_admitted, n_drop_thresh, n_drop_full);
    $display("Dequeues: %0d returned a packet (%0d ECN marked), %0d found the queue empty.",
             n_popped, n_marked, n_empty_pops);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
